[hdl/connectivity_change_count_macros.svh]
// ---------------------------------------------------------------------------
// Connectivity change counter assertion macros
// Property checks shared by the RTL; empty when synthesised.
// ---------------------------------------------------------------------------
`ifndef CONNECTIVITY_CHANGE_COUNT_MACROS_SVH
`define CONNECTIVITY_CHANGE_COUNT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define CCC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define CCC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CCC_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define CCC_ASSERT_NXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

[hdl/ccc_pkg.sv]
// ---------------------------------------------------------------------------
// Connectivity change counter package
// Shared widths, limits and the control bundle carried along the chain.
// ---------------------------------------------------------------------------
package ccc_pkg;

    localparam int LABEL_W         = 8;
    localparam int COUNT_W         = 15;
    localparam int MAX_SAMPLES_DEF = 256;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // control bits that travel with each word
    typedef struct packed {
        logic valid;
        logic last;
        logic ovf;
    } ccc_ctl_t;

endpackage

[hdl/ccc_cell.sv]
// ---------------------------------------------------------------------------
// Connectivity change counter cell
// Holds one stored label pair and counts mismatches for passing words.
// ---------------------------------------------------------------------------
module ccc_cell
    import ccc_pkg::*;
#(
    parameter int IDX_W      = 9,
    parameter int CNT_W      = 8,
    parameter int CELL_INDEX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  ccc_ctl_t            ctl_in,
    input  logic [LABEL_W-1:0]  now_in,
    input  logic [LABEL_W-1:0]  before_in,
    input  logic [IDX_W-1:0]    idx_in,
    input  logic [CNT_W-1:0]    cnt_in,
    output ccc_ctl_t            ctl_out,
    output logic [LABEL_W-1:0]  now_out,
    output logic [LABEL_W-1:0]  before_out,
    output logic [IDX_W-1:0]    idx_out,
    output logic [CNT_W-1:0]    cnt_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic [LABEL_W-1:0] stored_now_reg;
    logic [LABEL_W-1:0] stored_before_reg;
    ccc_ctl_t           ctl_reg;
    logic [LABEL_W-1:0] now_reg;
    logic [LABEL_W-1:0] before_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               hit;
    logic               store_en;

    always_comb begin
        // only samples earlier in the same vector live below this word's index
        hit      = ctl_in.valid && !ctl_in.ovf && (idx_in > MY_IDX) &&
                   ((stored_now_reg == now_in) != (stored_before_reg == before_in));
        cnt_next = cnt_in + CNT_W'(hit);
        store_en = adv && ctl_in.valid && !ctl_in.ovf && (idx_in == MY_IDX);
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            stored_now_reg    <= now_in;
            stored_before_reg <= before_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            now_reg    <= now_in;
            before_reg <= before_in;
            idx_reg    <= idx_in;
            cnt_reg    <= cnt_next;
        end
    end

    assign ctl_out    = ctl_reg;
    assign now_out    = now_reg;
    assign before_out = before_reg;
    assign idx_out    = idx_reg;
    assign cnt_out    = cnt_reg;

endmodule

[hdl/ccc_acc.sv]
// ---------------------------------------------------------------------------
// Connectivity change counter accumulator
// Sums per-word counts at the chain tail and holds the result word.
// ---------------------------------------------------------------------------
`include "connectivity_change_count_macros.svh"

module ccc_acc
    import ccc_pkg::*;
#(
    parameter int CNT_W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  ccc_ctl_t            ctl_in,
    input  logic [CNT_W-1:0]    cnt_in,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [COUNT_W-1:0]  m_changed_pairs,
    output logic                m_overflowed
);

    localparam int SUM_W = COUNT_W + 1;

    logic [COUNT_W-1:0] running_count_reg;
    logic               overflow_seen_reg;
    logic               m_valid_reg;
    logic [COUNT_W-1:0] m_changed_pairs_reg;
    logic               m_overflowed_reg;
    logic [SUM_W-1:0]   sum_full;
    logic [COUNT_W-1:0] sum_next;
    logic               ovf_next;

    always_comb begin
        sum_full = SUM_W'(running_count_reg) + SUM_W'(cnt_in);
        sum_next = (sum_full > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum_full[COUNT_W-1:0];
        ovf_next = overflow_seen_reg | ctl_in.ovf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_count_reg <= '0;
            overflow_seen_reg <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= ctl_in.valid && ctl_in.last;
            if (ctl_in.valid) begin
                if (ctl_in.last) begin
                    running_count_reg <= '0;
                    overflow_seen_reg <= 1'b0;
                end else begin
                    running_count_reg <= sum_next;
                    overflow_seen_reg <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && ctl_in.valid && ctl_in.last) begin
            m_changed_pairs_reg <= sum_next;
            m_overflowed_reg    <= ovf_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_changed_pairs = m_changed_pairs_reg;
    assign m_overflowed    = m_overflowed_reg;

    `CCC_ASSERT_IMP(a_result_from_last, aclk, aresetn, $rose(m_valid_reg), $past(ctl_in.valid && ctl_in.last), "result word without a last word at the tail")
    `CCC_ASSERT_NXT(a_count_cleared, aclk, aresetn, adv && ctl_in.valid && ctl_in.last, (running_count_reg == '0) && !overflow_seen_reg, "count not cleared after last word")

endmodule

[hdl/connectivity_change_count.sv]
// ---------------------------------------------------------------------------
// Connectivity change counter
// Counts sample pairs whose same-cluster relation changed between rounds.
// ---------------------------------------------------------------------------
// Words enter a row of MAX_SAMPLES cells, one cell per sample slot, and step
// one cell per cycle while the row moves; sample k is kept in cell k and
// every later word of the vector compares against it on its way past. One
// word is taken every cycle unless the row holds. A vector's result is
// registered once its last word leaves the row. While a result word waits
// on m_ready the whole row holds. Samples beyond MAX_SAMPLES in one vector
// are not compared and raise m_overflowed; the count saturates at 32767.
`include "connectivity_change_count_macros.svh"

module connectivity_change_count
    import ccc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [LABEL_W-1:0]  s_label_now,
    input  logic [LABEL_W-1:0]  s_label_before,
    input  logic                s_is_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COUNT_W-1:0]  m_changed_pairs,
    output logic                m_overflowed
);

    localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
    localparam int CNT_W = $clog2(MAX_SAMPLES);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_SAMPLES);

    logic               adv;
    logic               s_accept;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    ccc_ctl_t           head_ctl;

    ccc_ctl_t           ctl_w    [0:MAX_SAMPLES];
    logic [LABEL_W-1:0] now_w    [0:MAX_SAMPLES];
    logic [LABEL_W-1:0] before_w [0:MAX_SAMPLES];
    logic [IDX_W-1:0]   idx_w    [0:MAX_SAMPLES];
    logic [CNT_W-1:0]   cnt_w    [0:MAX_SAMPLES];

    // the row moves whenever the result register is free or being emptied
    assign adv      = !m_valid || m_ready;
    assign s_ready  = adv;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        idx_next = idx_reg;
        if (s_accept) begin
            if (s_is_last) begin
                idx_next = '0;
            end else if (idx_reg != MAX_IDX) begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    always_comb begin
        head_ctl.valid = s_accept;
        head_ctl.last  = s_is_last;
        head_ctl.ovf   = (idx_reg == MAX_IDX);
    end

    assign ctl_w[0]    = head_ctl;
    assign now_w[0]    = s_label_now;
    assign before_w[0] = s_label_before;
    assign idx_w[0]    = idx_reg;
    assign cnt_w[0]    = '0;

    for (genvar k = 0; k < MAX_SAMPLES; k++) begin : g_cell
        ccc_cell #(
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .CELL_INDEX (k)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .adv        (adv),
            .ctl_in     (ctl_w[k]),
            .now_in     (now_w[k]),
            .before_in  (before_w[k]),
            .idx_in     (idx_w[k]),
            .cnt_in     (cnt_w[k]),
            .ctl_out    (ctl_w[k+1]),
            .now_out    (now_w[k+1]),
            .before_out (before_w[k+1]),
            .idx_out    (idx_w[k+1]),
            .cnt_out    (cnt_w[k+1])
        );
    end

    ccc_acc #(
        .CNT_W (CNT_W)
    ) u_acc (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .ctl_in          (ctl_w[MAX_SAMPLES]),
        .cnt_in          (cnt_w[MAX_SAMPLES]),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_changed_pairs (m_changed_pairs),
        .m_overflowed    (m_overflowed)
    );

    `CCC_ASSERT_NXT(a_idx_restart, aclk, aresetn,
        s_accept && s_is_last, idx_reg == '0,
        "sample index not restarted after last word")
    `CCC_ASSERT_NXT(a_idx_step, aclk, aresetn,
        s_accept && !s_is_last && (idx_reg != MAX_IDX),
        idx_reg == $past(idx_reg) + 1'b1, "sample index did not step")
    `CCC_ASSERT_IMP(a_ovf_no_count, aclk, aresetn,
        ctl_w[MAX_SAMPLES].valid && ctl_w[MAX_SAMPLES].ovf,
        cnt_w[MAX_SAMPLES] == '0, "overflow word picked up pair counts")

endmodule
